### rtl/in_order_flush_position_tracker_defines.svh
// ----------------------------------------------------------------------------
// In-order flush position tracker: assertion macros
// Helpers for the concurrent checks in the scan sequencer.
// ----------------------------------------------------------------------------
`ifndef IN_ORDER_FLUSH_POSITION_TRACKER_DEFINES_SVH
`define IN_ORDER_FLUSH_POSITION_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk and masked during rst
`define IFPT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and masked during rst
`define IFPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ifpt_pkg.sv
// ----------------------------------------------------------------------------
// ifpt_pkg
// Types and constants shared by the flush position tracker modules.
// ----------------------------------------------------------------------------
package ifpt_pkg;

  // Ring of writer slots
  localparam int RING_SLOTS = 8;
  localparam int SLOT_W     = $clog2(RING_SLOTS);
  localparam int LAP_W      = $clog2(RING_SLOTS + 1);

  // Field widths
  localparam int IDX_W = 3;
  localparam int POS_W = 64;
  localparam int CAP_W = 25;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(4096);

  // Scan sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MIN,
    S_CMP,
    S_EQ,
    S_ADV,
    S_DONE
  } seq_state_t;

  // Request to the shared add/subtract unit
  typedef struct packed {
    logic [POS_W-1:0] a;
    logic [POS_W-1:0] b;
    logic             sub;
  } alu_req_t;

  // Response from the shared add/subtract unit
  typedef struct packed {
    logic [POS_W-1:0] sum;
    logic             neg;
    logic             zero;
  } alu_rsp_t;

endpackage

### rtl/in_order_flush_position_tracker.sv
// ----------------------------------------------------------------------------
// in_order_flush_position_tracker
// Tracks the contiguous flushed log position from out-of-order slot reports.
// ----------------------------------------------------------------------------
//   channel  | handshake                | payload
//   ---------+--------------------------+-------------------------------------
//   request  | in_valid / in_stall      | slot_index[2:0], slot_position[63:0]
//   result   | out_valid / out_stall    | flush_position[63:0], advanced
//   config   | cfg_wr_en                | cfg_wr_data[24:0] (bytes per window)
//
// A request runs from acceptance to the result register through a scan that
// stops at the first window left incomplete or after a full lap
// of eight windows. Each window costs four passes through the single
// shared 64-bit adder.
// in_stall is high from acceptance until the result is loaded.
// A result waiting under out_stall does not block the next request, but a
// second result is held back until the first one is taken.
// rst is synchronous; the slot table reads zero until each slot is written.
// ----------------------------------------------------------------------------
module in_order_flush_position_tracker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ifpt_pkg::IDX_W-1:0] slot_index,
  input  logic [ifpt_pkg::POS_W-1:0] slot_position,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ifpt_pkg::POS_W-1:0] flush_position,
  output logic                       advanced,
  input  logic                       cfg_wr_en,
  input  logic [ifpt_pkg::CAP_W-1:0] cfg_wr_data
);
  import ifpt_pkg::*;

  logic [CAP_W-1:0]  window_bytes;
  logic              accept;
  logic              busy;
  logic [SLOT_W-1:0] scan_slot;
  logic [POS_W-1:0]  slot_pos;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_bytes <= CAPACITY_RESET;
    end else if (cfg_wr_en) begin
      window_bytes <= cfg_wr_data;
    end
  end

  // Take a request only while the sequencer is idle
  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  ifpt_slot_table u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_addr (SLOT_W'(slot_index)),
    .wr_data (slot_position),
    .rd_addr (scan_slot),
    .rd_data (slot_pos)
  );

  ifpt_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  ifpt_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .start          (accept),
    .busy           (busy),
    .capacity       (window_bytes),
    .scan_slot      (scan_slot),
    .slot_pos       (slot_pos),
    .alu_req        (alu_req),
    .alu_rsp        (alu_rsp),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .flush_position (flush_position),
    .advanced       (advanced)
  );

endmodule

### rtl/ifpt_alu.sv
// ----------------------------------------------------------------------------
// ifpt_alu
// Shared 64-bit add/subtract unit with sign and zero flags.
// ----------------------------------------------------------------------------
module ifpt_alu (
  input  ifpt_pkg::alu_req_t req,
  output ifpt_pkg::alu_rsp_t rsp
);
  import ifpt_pkg::*;

  logic [POS_W-1:0] b_eff;
  logic [POS_W-1:0] sum;

  // Subtract as a plus inverted b plus one
  assign b_eff = req.sub ? ~req.b : req.b;
  assign sum   = req.a + b_eff + POS_W'(req.sub);

  // Flags: the sign bit gives modulo order
  assign rsp.sum  = sum;
  assign rsp.neg  = sum[POS_W-1];
  assign rsp.zero = (sum == '0);

endmodule

### rtl/ifpt_slot_table.sv
// ----------------------------------------------------------------------------
// ifpt_slot_table
// Per-slot flushed positions with valid bits; unwritten slots read as zero.
// ----------------------------------------------------------------------------
module ifpt_slot_table (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [ifpt_pkg::SLOT_W-1:0] wr_addr,
  input  logic [ifpt_pkg::POS_W-1:0]  wr_data,
  input  logic [ifpt_pkg::SLOT_W-1:0] rd_addr,
  output logic [ifpt_pkg::POS_W-1:0]  rd_data
);
  import ifpt_pkg::*;

  logic [POS_W-1:0]      entry [RING_SLOTS];
  logic [RING_SLOTS-1:0] valid;

  // Mark written slots
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Store reported position
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry[wr_addr] <= wr_data;
    end
  end

  // Read the scan slot; zero until first written
  assign rd_data = valid[rd_addr] ? entry[rd_addr] : '0;

endmodule

### rtl/ifpt_seq.sv
// ----------------------------------------------------------------------------
// ifpt_seq
// Scan sequencer: drives the shared unit through clamp, compare, window
// check and window advance, and holds the result register.
// ----------------------------------------------------------------------------
`include "in_order_flush_position_tracker_defines.svh"

module ifpt_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [ifpt_pkg::CAP_W-1:0]  capacity,
  output logic [ifpt_pkg::SLOT_W-1:0] scan_slot,
  input  logic [ifpt_pkg::POS_W-1:0]  slot_pos,
  output ifpt_pkg::alu_req_t          alu_req,
  input  ifpt_pkg::alu_rsp_t          alu_rsp,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ifpt_pkg::POS_W-1:0]  flush_position,
  output logic                        advanced
);
  import ifpt_pkg::*;

  seq_state_t       state;
  seq_state_t       state_next;
  logic [POS_W-1:0] contig;
  logic [POS_W-1:0] window_end;
  logic [POS_W-1:0] target;
  logic [LAP_W-1:0] laps;
  logic             moved;
  logic [POS_W-1:0] cap_ext;
  logic             out_free;
  logic             last_lap;

  assign cap_ext  = {{(POS_W-CAP_W){1'b0}}, capacity};
  assign out_free = !out_valid || !out_stall;
  assign last_lap = (laps == LAP_W'(RING_SLOTS - 1));
  assign busy     = (state != S_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and shared unit operands
  always_comb begin
    state_next  = state;
    alu_req.a   = contig;
    alu_req.b   = window_end;
    alu_req.sub = 1'b1;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_MIN;
      end
      S_MIN: begin
        // window_end - slot: negative means window end lies first
        alu_req.a  = window_end;
        alu_req.b  = slot_pos;
        state_next = S_CMP;
      end
      S_CMP: begin
        alu_req.a  = contig;
        alu_req.b  = target;
        state_next = S_EQ;
      end
      S_EQ: begin
        alu_req.a  = contig;
        alu_req.b  = window_end;
        state_next = alu_rsp.zero ? S_ADV : S_DONE;
      end
      S_ADV: begin
        alu_req.a   = window_end;
        alu_req.b   = cap_ext;
        alu_req.sub = 1'b0;
        state_next  = last_lap ? S_DONE : S_MIN;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Scan datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      contig     <= '0;
      window_end <= {{(POS_W-CAP_W){1'b0}}, CAPACITY_RESET};
      scan_slot  <= '0;
      laps       <= '0;
      moved      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            laps  <= '0;
            moved <= 1'b0;
          end
        end
        S_CMP: begin
          // Advance the flush position when it lies before the target
          if (alu_rsp.neg) begin
            contig <= target;
            moved  <= 1'b1;
          end
        end
        S_ADV: begin
          window_end <= alu_rsp.sum;
          scan_slot  <= (scan_slot == SLOT_W'(RING_SLOTS - 1)) ? '0 : scan_slot + 1'b1;
          laps       <= laps + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Clamp the slot position to the window end
  always_ff @(posedge clk) begin
    if (state == S_MIN) begin
      target <= alu_rsp.neg ? window_end : slot_pos;
    end
  end

  // Result register: hold until taken, load when free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      flush_position <= contig;
      advanced       <= moved;
    end
  end

  `IFPT_ASSERT_SAME(a_lap_bound, state != S_IDLE, laps <= LAP_W'(RING_SLOTS), "lap count overran")
  `IFPT_ASSERT_NEXT(a_advance_to_target, state == S_CMP && alu_rsp.neg, contig == $past(target) && moved, "flush position missed target")
  `IFPT_ASSERT_NEXT(a_window_step, state == S_ADV, window_end == $past(window_end) + $past(cap_ext), "window end step wrong")
  `IFPT_ASSERT_NEXT(a_result_load, state == S_DONE && out_free, out_valid && state == S_IDLE && flush_position == contig, "result not loaded")

endmodule

### sim/flush_tracker_checker.sv
// ----------------------------------------------------------------------------
// flush_tracker_checker
// Watches the request, result and capacity ports of the flush position
// tracker, keeps its own copy of the slot table and scan state, predicts
// the result of every accepted request and compares the results in order.
// ----------------------------------------------------------------------------
module flush_tracker_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [ifpt_pkg::IDX_W-1:0]  slot_index,
  input  logic [ifpt_pkg::POS_W-1:0]  slot_position,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [ifpt_pkg::POS_W-1:0]  flush_position,
  input  logic                        advanced,
  input  logic                        cfg_wr_en,
  input  logic [ifpt_pkg::CAP_W-1:0]  cfg_wr_data,
  output int                          pending_results,
  output logic [ifpt_pkg::POS_W-1:0]  pred_window_end,
  output logic [ifpt_pkg::SLOT_W-1:0] pred_scan_slot,
  output int                          fail_count
);
  import ifpt_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0] flush;
    logic             moved;
  } flush_result_t;

  // Predicted tracker state
  logic [POS_W-1:0]  slot_table [RING_SLOTS];
  logic [POS_W-1:0]  contig_pos;
  logic [SLOT_W-1:0] scan_idx;
  logic [POS_W-1:0]  window_limit;
  logic [CAP_W-1:0]  capacity;

  flush_result_t expected_flush_q [$];

  // a lies before b when a - b is negative as a signed 64-bit value
  function automatic logic wraps_before(input logic [POS_W-1:0] a, input logic [POS_W-1:0] b);
    logic [POS_W-1:0] diff;
    diff = a - b;
    return diff[POS_W-1];
  endfunction

  // Record one slot report, then walk the ring for at most one lap
  function automatic flush_result_t advance_flush(input logic [IDX_W-1:0] idx,
                                                  input logic [POS_W-1:0] pos);
    flush_result_t    res;
    logic [POS_W-1:0] target;
    logic             moved;
    logic             stop;
    int               laps;
    slot_table[idx] = pos;
    moved = 1'b0;
    stop  = 1'b0;
    laps  = 0;
    while (!stop) begin
      // clamp the slot's position to its window end
      target = wraps_before(window_limit, slot_table[scan_idx]) ?
               window_limit : slot_table[scan_idx];
      if (wraps_before(contig_pos, target)) begin
        contig_pos = target;
        moved      = 1'b1;
      end
      if (contig_pos != window_limit) begin
        stop = 1'b1;
      end else begin
        scan_idx     = scan_idx + 1'b1;
        window_limit = window_limit + POS_W'(capacity);
        laps++;
        if (laps >= RING_SLOTS) stop = 1'b1;
      end
    end
    res.flush = contig_pos;
    res.moved = moved;
    return res;
  endfunction

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input logic [POS_W-1:0] want,
                                 input logic [POS_W-1:0] got);
    fail_count++;
    $display("mismatch on %s: expected %h, got %h", what, want, got);
  endtask

  always @(posedge clk) begin : watch
    flush_result_t want;
    if (rst) begin
      for (int i = 0; i < RING_SLOTS; i++) slot_table[i] = '0;
      contig_pos   = '0;
      scan_idx     = '0;
      capacity     = CAPACITY_RESET;
      window_limit = POS_W'(CAPACITY_RESET);
      fail_count   = 0;
      expected_flush_q.delete();
    end else begin
      // capacity writes must land while the block is idle (not enforced)
      if (cfg_wr_en) capacity = cfg_wr_data;
      // compare the result against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_flush_q.size() == 0) begin
          report_mismatch("result with no request outstanding", '0, flush_position);
        end else begin
          want = expected_flush_q.pop_front();
          if (flush_position !== want.flush)
            report_mismatch("flush_position", want.flush, flush_position);
          if (advanced !== want.moved)
            report_mismatch("advanced", POS_W'(want.moved), POS_W'(advanced));
        end
      end
      // predict the result of an accepted request
      if (in_valid && !in_stall)
        expected_flush_q.push_back(advance_flush(slot_index, slot_position));
    end
    pending_results <= expected_flush_q.size();
    pred_window_end <= window_limit;
    pred_scan_slot  <= scan_idx;
  end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives slot reports and capacity writes into the flush position tracker:
// a short directed run over position extremes, out-of-order completion and
// full-lap scans, then random phases at several block capacities made mostly
// of in-order window completions with noise mixed in. Both handshakes idle
// at random; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import ifpt_pkg::*;

  localparam int IDLE_LIMIT     = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int PHASE_REQUESTS = 180;

  logic             clk           = 1'b0;
  logic             rst           = 1'b1;
  logic             in_valid      = 1'b0;
  logic             in_stall;
  logic [IDX_W-1:0] slot_index    = '0;
  logic [POS_W-1:0] slot_position = '0;
  logic             out_valid;
  logic             out_stall     = 1'b0;
  logic [POS_W-1:0] flush_position;
  logic             advanced;
  logic             cfg_wr_en     = 1'b0;
  logic [CAP_W-1:0] cfg_wr_data   = '0;

  int                pending_results;
  logic [POS_W-1:0]  pred_window_end;
  logic [SLOT_W-1:0] pred_scan_slot;
  int                fail_count;

  int cap_now    = int'(CAPACITY_RESET);
  logic in_quiet  = 1'b0;
  logic out_quiet = 1'b0;
  int stall_left  = 0;
  int idle_cycles = 0;

  in_order_flush_position_tracker dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .slot_index     (slot_index),
    .slot_position  (slot_position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .flush_position (flush_position),
    .advanced       (advanced),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  flush_tracker_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .slot_index      (slot_index),
    .slot_position   (slot_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .flush_position  (flush_position),
    .advanced        (advanced),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .pending_results (pending_results),
    .pred_window_end (pred_window_end),
    .pred_scan_slot  (pred_scan_slot),
    .fail_count      (fail_count)
  );

  always #6 clk = ~clk;

  // Result side: stall for a random number of cycles after each result
  always @(posedge clk) begin : result_stall
    int hold;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      hold = out_quiet ? 0 : $urandom_range(0, 6);
      out_stall  <= (hold != 0);
      stall_left <= hold;
      if ($urandom_range(0, 39) == 0) out_quiet <= ~out_quiet;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end
  end

  // Watchdog: give up after a long stretch with no handshake at all
  always @(posedge clk) begin
    if (rst || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("in_order_flush_position_tracker verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int draw_gap();
    return in_quiet ? 0 : $urandom_range(0, 6);
  endfunction

  // Drop the request valid and let the given number of cycles pass
  task automatic idle_input(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Present one request and hold it until accepted
  task automatic send_report(input logic [IDX_W-1:0] idx, input logic [POS_W-1:0] pos,
                             input int gap);
    idle_input(gap);
    in_valid      <= 1'b1;
    slot_index    <= idx;
    slot_position <= pos;
    do @(posedge clk); while (in_stall);
  endtask

  // Wait until every result has come back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cap_now     = int'(value);
  endtask

  // Fill every slot far ahead, completing slot scan_slot last: one lap, then a resume
  task automatic run_full_lap();
    logic [POS_W-1:0]  base;
    logic [SLOT_W-1:0] first;
    idle_input(1);
    base  = pred_window_end + POS_W'(1000) * POS_W'(cap_now);
    first = pred_scan_slot;
    for (int k = RING_SLOTS - 1; k >= 0; k--)
      send_report(first + SLOT_W'(k), base, 0);
    send_report(first + SLOT_W'(3), base, 1);
  endtask

  // One batch: mostly in-order window completions, sometimes noise
  task automatic run_batch(output int sent);
    logic [POS_W-1:0]  w;
    logic [POS_W-1:0]  window_stop;
    logic [SLOT_W-1:0] s;
    logic [IDX_W-1:0]  b_slot [RING_SLOTS];
    logic [POS_W-1:0]  b_pos  [RING_SLOTS];
    logic [IDX_W-1:0]  t_slot;
    logic [POS_W-1:0]  t_pos;
    int                n;
    int                k;
    if ($urandom_range(0, 9) == 0) in_quiet = ~in_quiet;
    // idle the input first so the predicted scan state is current
    idle_input(in_quiet ? 1 : $urandom_range(1, 6));
    w = pred_window_end;
    s = pred_scan_slot;
    if ($urandom_range(0, 9) < 7) begin
      n = $urandom_range(1, RING_SLOTS);
      for (int j = 0; j < n; j++) begin
        window_stop = w + POS_W'(j) * POS_W'(cap_now);
        b_slot[j]   = s + SLOT_W'(j);
        case ($urandom_range(0, 5))
          0:       b_pos[j] = window_stop - POS_W'($urandom_range(0, cap_now));
          1:       b_pos[j] = window_stop + POS_W'($urandom_range(0, 4 * cap_now));
          default: b_pos[j] = window_stop;
        endcase
      end
      // shuffle so that writers finish out of order
      for (int j = n - 1; j > 0; j--) begin
        k         = $urandom_range(0, j);
        t_slot    = b_slot[j];
        t_pos     = b_pos[j];
        b_slot[j] = b_slot[k];
        b_pos[j]  = b_pos[k];
        b_slot[k] = t_slot;
        b_pos[k]  = t_pos;
      end
    end else begin
      n = $urandom_range(1, 3);
      for (int j = 0; j < n; j++) begin
        b_slot[j] = IDX_W'($urandom_range(0, RING_SLOTS - 1));
        case ($urandom_range(0, 3))
          0:       b_pos[j] = {$urandom, $urandom};
          1:       b_pos[j] = w + POS_W'($urandom_range(0, 3 * cap_now));
          2:       b_pos[j] = w - POS_W'($urandom_range(0, 8 * cap_now + 1));
          default: b_pos[j] = w + 64'h8000_0000_0000_0000 - POS_W'($urandom_range(0, 1));
        endcase
      end
    end
    for (int j = 0; j < n; j++)
      send_report(b_slot[j], b_pos[j], (j == 0) ? 0 : draw_gap());
    sent = n;
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] value);
    int sent;
    int total;
    write_capacity(value);
    total = 0;
    while (total < PHASE_REQUESTS) begin
      run_batch(sent);
      total += sent;
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: out-of-order completion at the reset capacity
    send_report(3'd1, 64'd8192, 0);
    send_report(3'd0, 64'd4096, 1);
    send_report(3'd2, 64'd9000, 0);
    send_report(3'd2, 64'd0, 2);
    send_report(3'd3, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_report(3'd2, 64'd12288, 0);
    send_report(3'd3, 64'h8000_0000_0000_0000, 3);
    send_report(3'd4, 64'h7FFF_FFFF_FFFF_FFFF, 0);
    send_report(3'd5, 64'd0, 0);
    send_report(3'd6, 64'hFFFF_FFFF_FFFF_FFFF, 1);
    send_report(3'd7, 64'h5555_5555_AAAA_AAAA, 0);
    // Directed: every slot complete, the scan stops after one lap and resumes
    run_full_lap();
    drain();

    // Random phases over a spread of block capacities
    run_phase(CAP_W'(1));
    run_phase(CAP_W'(16777216));
    run_phase('1);
    run_phase(CAP_W'(0));
    run_phase(CAP_W'($urandom_range(2, 16777215)));
    run_phase(CAPACITY_RESET);

    if (fail_count == 0) begin
      $display("in_order_flush_position_tracker verification clean");
    end else begin
      $display("in_order_flush_position_tracker verification failed");
    end
    $finish;
  end

endmodule
